@@ rtl/core/pfte_pkg.sv @@
// ---------------------------------------------------------------------------
// pfte_pkg: shared types and constants of the page framebuffer text engine
// Command codes, state encoding and default geometry.
// ---------------------------------------------------------------------------
`default_nettype none
package pfte_pkg;

  localparam int PAGE_WIDTH_DEF        = 128;
  localparam int PAGE_COUNT_DEF        = 8;
  localparam int PANEL_HEIGHT_DEF      = 64;
  localparam int GLYPH_COUNT_DEF       = 96;
  localparam int MAX_GLYPH_COLUMNS_DEF = 8;
  localparam int BLANK_COLUMNS         = 5;

  // Configuration register indexes.
  localparam logic [7:0] CFG_FIRST_GLYPH = 8'd0;
  localparam logic [7:0] CFG_LAST_GLYPH  = 8'd1;
  localparam logic [7:0] CFG_FONT_PRESENT = 8'd2;

  typedef enum logic [3:0] {
    MODE_CLEAR_ALL  = 4'd0,
    MODE_WRITE_BYTE = 4'd1,
    MODE_CLEAR_PAGE = 4'd2,
    MODE_HLINE      = 4'd3,
    MODE_TEXT_START = 4'd4,
    MODE_TEXT_CHAR  = 4'd5,
    MODE_PLACE_CHAR = 4'd6,
    MODE_FONT_LOAD  = 4'd7,
    MODE_READ       = 4'd8,
    MODE_MARK_SENT  = 4'd9
  } mode_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_FILL,
    ST_LINE_RD,
    ST_LINE_WR,
    ST_READ_WAIT,
    ST_WIDTH_RD,
    ST_WIDTH_WAIT,
    ST_GLYPH_RD,
    ST_GLYPH_WR,
    ST_BLANK,
    ST_DONE
  } state_t;

endpackage
`default_nettype wire

@@ rtl/core/pfte_ram.sv @@
// ---------------------------------------------------------------------------
// pfte_ram: generic single-port synchronous RAM
// One write or read per cycle, read data registered.
// ---------------------------------------------------------------------------
`default_nettype none
module pfte_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 1024
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] addr,
  input  wire logic [WIDTH-1:0]         wdata,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write or registered read at one address.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule
`default_nettype wire

@@ rtl/core/page_framebuffer_text_engine.sv @@
// ---------------------------------------------------------------------------
// page_framebuffer_text_engine: page-organised monochrome framebuffer
// Frame store and font store in RAM, commands run by a small sequencer.
// ---------------------------------------------------------------------------
// Usage: one command transaction on the in_ channel gives exactly one result
// transaction on the out_ channel (read data, dirty flag, ignored flag).
// Commands are handled one at a time by a sequencer round the frame RAM and
// the font RAM, each with one port and a registered read.
// Steps: register-only commands and write byte act when accepted; read
// waits for the registered read data; clear all and clear page write one byte
// per cycle; a horizontal line reads then writes each byte; a text character
// reads the glyph width, then reads and writes each glyph column, at most
// MAX_GLYPH_COLUMNS, and adds one blank column, or BLANK_COLUMNS blank columns
// without a glyph; place char copies the glyph columns only. The byte-serial
// frame RAM port sets this pace.
// A new command can be accepted in the cycle after the previous result is taken
// from the output register; while the receiver stalls the result is held and no
// command is taken. Reset clears the control state, text cursor and dirty
// flag and loads the glyph range defaults; the frame store is undefined until
// a clear all and the font store until loaded.
// ---------------------------------------------------------------------------
`default_nettype none
module page_framebuffer_text_engine #(
  parameter int PAGE_WIDTH        = pfte_pkg::PAGE_WIDTH_DEF,
  parameter int PAGE_COUNT        = pfte_pkg::PAGE_COUNT_DEF,
  parameter int PANEL_HEIGHT      = pfte_pkg::PANEL_HEIGHT_DEF,
  parameter int GLYPH_COUNT       = pfte_pkg::GLYPH_COUNT_DEF,
  parameter int MAX_GLYPH_COLUMNS = pfte_pkg::MAX_GLYPH_COLUMNS_DEF
) (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_valid,
  output logic            in_ready,
  input  wire logic [3:0] in_mode,
  input  wire logic [9:0] in_address,
  input  wire logic [7:0] in_value,
  input  wire logic [3:0] in_page,
  input  wire logic [6:0] in_line_y,
  input  wire logic [6:0] in_column_x,
  input  wire logic [7:0] in_char_code,
  input  wire logic [6:0] in_glyph_index,
  input  wire logic [3:0] in_glyph_column,
  output logic            out_valid,
  input  wire logic       out_ready,
  output logic      [7:0] out_read_data,
  output logic            out_dirty,
  output logic            out_ignored,
  input  wire logic       cfg_we,
  input  wire logic [7:0] cfg_index,
  input  wire logic [7:0] cfg_data
);
  import pfte_pkg::*;

  localparam int FRAME_SIZE   = PAGE_WIDTH * PAGE_COUNT;
  localparam int STRIDE       = MAX_GLYPH_COLUMNS + 1;
  localparam int FONT_SIZE    = GLYPH_COUNT * STRIDE;
  localparam int FA           = $clog2(FRAME_SIZE);
  localparam int GA           = $clog2(FONT_SIZE);
  localparam int PW           = (FA > 10) ? FA + 1 : 11;
  localparam int CW           = ($clog2(MAX_GLYPH_COLUMNS + 1) > 3)
                                ? $clog2(MAX_GLYPH_COLUMNS + 1) : 3;
  localparam int SW           = $clog2(GLYPH_COUNT + 1);

  // Configuration registers.
  logic [7:0] first_r, last_r;
  logic       font_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      first_r <= 8'd32;
      last_r  <= 8'd127;
      font_r  <= 1'b0;
    end else if (cfg_we) begin
      if (cfg_index == CFG_FIRST_GLYPH) first_r <= cfg_data;
      if (cfg_index == CFG_LAST_GLYPH)  last_r  <= cfg_data;
      if (cfg_index == CFG_FONT_PRESENT) font_r <= cfg_data[0];
    end
  end

  // Sequencer state.
  state_t       st_r, st_nxt;
  logic [PW-1:0] pos_r, pos_nxt, end_r, end_nxt;
  logic [PW-1:0] cur_r, cur_nxt, pend_r, pend_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt, wid_r, wid_nxt;
  logic [GA-1:0] gbase_r, gbase_nxt;
  logic          blank_r, blank_nxt, cursor_upd_r, cursor_upd_nxt;
  logic [7:0]    bit_r, bit_nxt;
  logic          dirty_r, dirty_nxt;
  logic [7:0]    rd_r, rd_nxt;
  logic          ign_r, ign_nxt, ov_r, ov_nxt;

  // Memory ports.
  logic          f_we;
  logic [FA-1:0] f_addr;
  logic [7:0]    f_wdata, f_rdata;
  logic          g_we;
  logic [GA-1:0] g_addr;
  logic [7:0]    g_wdata, g_rdata;

  pfte_ram #(.WIDTH(8), .DEPTH(FRAME_SIZE)) u_frame (
    .clk(clk), .we(f_we), .addr(f_addr), .wdata(f_wdata), .rdata(f_rdata)
  );
  pfte_ram #(.WIDTH(8), .DEPTH(FONT_SIZE)) u_font (
    .clk(clk), .we(g_we), .addr(g_addr), .wdata(g_wdata), .rdata(g_rdata)
  );

  assign in_ready      = (st_r == ST_IDLE) && !ov_r;
  assign out_valid     = ov_r;
  assign out_read_data = rd_r;
  assign out_dirty     = dirty_r;
  assign out_ignored   = ign_r;

  // Decoded command fields.
  logic          acc;
  logic [PW-1:0] tpage_base, line_base, page_base;
  logic [3:0]    tpage;
  logic [8:0]    code_off;
  logic          has_glyph;
  logic          in_addr_ok;
  logic [PW-1:0] gl_base_w;

  always_comb begin
    acc        = in_valid && in_ready;
    tpage      = ({1'b0, in_page} >= 5'(PAGE_COUNT)) ? 4'(PAGE_COUNT - 1) : in_page;
    tpage_base = PW'(tpage) * PW'(PAGE_WIDTH);
    page_base  = PW'(in_page) * PW'(PAGE_WIDTH);
    line_base  = PW'(in_line_y[6:3]) * PW'(PAGE_WIDTH);
    code_off   = {1'b0, in_char_code} - {1'b0, first_r};
    has_glyph  = (in_char_code >= first_r) && (in_char_code <= last_r)
                 && (code_off < 9'(GLYPH_COUNT));
    in_addr_ok = PW'(in_address) < PW'(FRAME_SIZE);
    gl_base_w  = PW'(code_off[SW-1:0]) * PW'(STRIDE);
  end

  // Next-state logic.
  always_comb begin
    st_nxt = st_r;
    unique case (st_r)
      ST_IDLE: begin
        if (acc) begin
          unique case (in_mode)
            MODE_CLEAR_ALL:  st_nxt = ST_FILL;
            MODE_CLEAR_PAGE: st_nxt = ({1'b0, in_page} < 5'(PAGE_COUNT)) ? ST_FILL : ST_DONE;
            MODE_HLINE: st_nxt = ({1'b0, in_line_y} < 8'(PANEL_HEIGHT)
                                  && {1'b0, in_line_y[6:3]} < 5'(PAGE_COUNT))
                                 ? ST_LINE_RD : ST_DONE;
            MODE_TEXT_CHAR: st_nxt = !font_r ? ST_DONE
                                     : (has_glyph ? ST_WIDTH_RD : ST_BLANK);
            MODE_PLACE_CHAR: st_nxt = (font_r && has_glyph) ? ST_WIDTH_RD : ST_DONE;
            MODE_READ: st_nxt = in_addr_ok ? ST_READ_WAIT : ST_DONE;
            default: st_nxt = ST_DONE;
          endcase
        end
      end
      ST_FILL:       st_nxt = (pos_r + 1'b1 >= end_r) ? ST_DONE : ST_FILL;
      ST_LINE_RD:    st_nxt = ST_LINE_WR;
      ST_LINE_WR:    st_nxt = (pos_r + 1'b1 >= end_r) ? ST_DONE : ST_LINE_RD;
      ST_READ_WAIT:  st_nxt = ST_DONE;
      ST_WIDTH_RD:   st_nxt = ST_WIDTH_WAIT;
      ST_WIDTH_WAIT: begin
        if (g_rdata == 8'd0 || pos_r >= end_r || pos_r >= PW'(FRAME_SIZE)) begin
          st_nxt = blank_r ? ST_BLANK : ST_DONE;
        end else begin
          st_nxt = ST_GLYPH_RD;
        end
      end
      ST_GLYPH_RD:   st_nxt = ST_GLYPH_WR;
      ST_GLYPH_WR: begin
        if (cnt_r + 1'b1 >= wid_r || pos_r + 1'b1 >= end_r
            || pos_r + 1'b1 >= PW'(FRAME_SIZE)) begin
          st_nxt = blank_r ? ST_BLANK : ST_DONE;
        end else begin
          st_nxt = ST_GLYPH_RD;
        end
      end
      ST_BLANK: begin
        if (cnt_r == '0 || pos_r >= end_r || pos_r >= PW'(FRAME_SIZE)) st_nxt = ST_DONE;
      end
      ST_DONE:       st_nxt = ST_IDLE;
      default:       st_nxt = ST_IDLE;
    endcase
  end

  // Datapath and memory control.
  always_comb begin
    pos_nxt = pos_r; end_nxt = end_r; cur_nxt = cur_r; pend_nxt = pend_r;
    cnt_nxt = cnt_r; wid_nxt = wid_r; gbase_nxt = gbase_r; blank_nxt = blank_r;
    cursor_upd_nxt = cursor_upd_r; bit_nxt = bit_r; dirty_nxt = dirty_r;
    rd_nxt = rd_r; ign_nxt = ign_r; ov_nxt = ov_r;
    f_we = 1'b0; f_addr = pos_r[FA-1:0]; f_wdata = 8'h00;
    g_we = 1'b0; g_addr = gbase_r; g_wdata = in_value;
    if (ov_r && out_ready) ov_nxt = 1'b0;

    unique case (st_r)
      ST_IDLE: begin
        if (acc) begin
          rd_nxt = 8'h00;
          ign_nxt = 1'b0;
          cursor_upd_nxt = 1'b0;
          blank_nxt = 1'b0;
          cnt_nxt = '0;
          gbase_nxt = gl_base_w[GA-1:0];
          f_addr = FA'(in_address);
          unique case (in_mode)
            MODE_CLEAR_ALL: begin
              pos_nxt = '0; end_nxt = PW'(FRAME_SIZE); dirty_nxt = 1'b1;
            end
            MODE_WRITE_BYTE: begin
              if (in_addr_ok) begin
                f_we = 1'b1; f_wdata = in_value; dirty_nxt = 1'b1;
              end else ign_nxt = 1'b1;
            end
            MODE_CLEAR_PAGE: begin
              pos_nxt = page_base; end_nxt = page_base + PW'(PAGE_WIDTH);
              if ({1'b0, in_page} < 5'(PAGE_COUNT)) dirty_nxt = 1'b1;
              else ign_nxt = 1'b1;
            end
            MODE_HLINE: begin
              pos_nxt = line_base; end_nxt = line_base + PW'(PAGE_WIDTH);
              bit_nxt = 8'h01 << in_line_y[2:0];
              if ({1'b0, in_line_y} < 8'(PANEL_HEIGHT)
                  && {1'b0, in_line_y[6:3]} < 5'(PAGE_COUNT)) dirty_nxt = 1'b1;
              else ign_nxt = 1'b1;
            end
            MODE_TEXT_START: begin
              if (font_r) begin
                cur_nxt = tpage_base; pend_nxt = tpage_base + PW'(PAGE_WIDTH);
                dirty_nxt = 1'b1;
              end else ign_nxt = 1'b1;
            end
            MODE_TEXT_CHAR: begin
              if (font_r) begin
                pos_nxt = cur_r; end_nxt = pend_r; dirty_nxt = 1'b1;
                cursor_upd_nxt = 1'b1; blank_nxt = 1'b1;
                cnt_nxt = has_glyph ? CW'(1) : CW'(BLANK_COLUMNS);
              end else ign_nxt = 1'b1;
            end
            MODE_PLACE_CHAR: begin
              if (font_r) begin
                pos_nxt = tpage_base + PW'(in_column_x);
                end_nxt = tpage_base + PW'(PAGE_WIDTH); dirty_nxt = 1'b1;
              end else ign_nxt = 1'b1;
            end
            MODE_FONT_LOAD: begin
              if ({2'b0, in_glyph_index} < 9'(GLYPH_COUNT)
                  && {1'b0, in_glyph_column} < 5'(STRIDE)) begin
                g_we = 1'b1;
                g_addr = GA'(PW'(in_glyph_index) * PW'(STRIDE) + PW'(in_glyph_column));
              end else ign_nxt = 1'b1;
            end
            MODE_READ:      ign_nxt = !in_addr_ok;
            MODE_MARK_SENT: dirty_nxt = 1'b0;
            default:        ign_nxt = 1'b1;
          endcase
        end
      end
      ST_FILL: begin
        f_we = 1'b1; pos_nxt = pos_r + 1'b1;
      end
      ST_LINE_RD: ;
      ST_LINE_WR: begin
        f_we = 1'b1; f_wdata = f_rdata | bit_r; pos_nxt = pos_r + 1'b1;
      end
      ST_READ_WAIT: rd_nxt = f_rdata;
      ST_WIDTH_RD: ;
      ST_WIDTH_WAIT: begin
        wid_nxt = (g_rdata > 8'(MAX_GLYPH_COLUMNS)) ? CW'(MAX_GLYPH_COLUMNS)
                                                   : CW'(g_rdata);
        // The column count starts at zero; a text character that skips its
        // glyph goes straight on to its one trailing blank column.
        cnt_nxt = '0;
        if (blank_r && st_nxt != ST_GLYPH_RD) cnt_nxt = CW'(1);
        gbase_nxt = gbase_r + 1'b1;
      end
      ST_GLYPH_RD: ;
      ST_GLYPH_WR: begin
        f_we = 1'b1; f_wdata = g_rdata; pos_nxt = pos_r + 1'b1;
        gbase_nxt = gbase_r + 1'b1;
        if (cnt_r + 1'b1 >= wid_r || pos_r + 1'b1 >= end_r
            || pos_r + 1'b1 >= PW'(FRAME_SIZE)) cnt_nxt = CW'(1);
        else cnt_nxt = cnt_r + 1'b1;
      end
      ST_BLANK: begin
        if (!(cnt_r == '0 || pos_r >= end_r || pos_r >= PW'(FRAME_SIZE))) begin
          f_we = 1'b1; pos_nxt = pos_r + 1'b1; cnt_nxt = cnt_r - 1'b1;
        end
      end
      ST_DONE: begin
        ov_nxt = 1'b1;
        if (cursor_upd_r) cur_nxt = pos_r;
      end
      default: ;
    endcase
  end

  // Registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= ST_IDLE; ov_r <= 1'b0; dirty_r <= 1'b0;
      cur_r <= '0; pend_r <= '0;
    end else begin
      st_r <= st_nxt; ov_r <= ov_nxt; dirty_r <= dirty_nxt;
      cur_r <= cur_nxt; pend_r <= pend_nxt;
    end
    pos_r <= pos_nxt; end_r <= end_nxt; cnt_r <= cnt_nxt; wid_r <= wid_nxt;
    gbase_r <= gbase_nxt; blank_r <= blank_nxt; cursor_upd_r <= cursor_upd_nxt;
    bit_r <= bit_nxt; rd_r <= rd_nxt; ign_r <= ign_nxt;
  end

endmodule
`default_nettype wire
